@@ hdl/drm_pkg.sv @@
// shared types, register indexes and the sequencer microprogram
`default_nettype none

package drm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd4;

    // register reset values
    localparam logic [15:0] GAIN_RST   = 16'd12845;
    localparam logic [15:0] PERIOD_RST = 16'd1311;
    localparam logic [15:0] TOL_RST    = 16'd655;

    // drive limits, Q1.14
    localparam logic signed [15:0] DRIVE_POS = 16'sd16384;
    localparam logic signed [15:0] DRIVE_NEG = -16'sd16384;
    localparam logic [14:0]        QUO_FULL  = 15'd16384;

    // quotient bits produced by the divider
    localparam int DIV_BITS = 15;
    localparam int CNT_W    = $clog2(DIV_BITS);

    // microprogram step addresses
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_WAIT_IN    = 4'd0;
    localparam step_t ST_MUL_V      = 4'd1;
    localparam step_t ST_ADD_V      = 4'd2;
    localparam step_t ST_MUL_P      = 4'd3;
    localparam step_t ST_ADD_P      = 4'd4;
    localparam step_t ST_CHECK      = 4'd5;
    localparam step_t ST_DIV_INIT   = 4'd6;
    localparam step_t ST_DIV_STEP   = 4'd7;
    localparam step_t ST_DRIVE_DIV  = 4'd8;
    localparam step_t ST_DRIVE_SIGN = 4'd9;
    localparam step_t ST_FINISH     = 4'd10;
    localparam step_t ST_EMIT       = 4'd11;

    // datapath operations
    typedef enum logic [3:0] {
        OP_LATCH,
        OP_MUL_V,
        OP_ADD_V,
        OP_MUL_P,
        OP_ADD_P,
        OP_CHECK,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DRIVE_DIV,
        OP_DRIVE_SIGN,
        OP_FINISH,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_IN_FIRE,
        CND_OUT_FREE,
        CND_DONE,
        CND_TZERO,
        CND_CNT_NZ
    } cond_t;

    // one control word: taken jump goes to target, otherwise next step or hold
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic done;
        logic tzero;
        logic cnt_nz;
    } flags_t;

    // microprogram rom
    function automatic ctrl_t seq_rom(input step_t s);
        ctrl_t c;
        c = '{op: OP_EMIT, cond: CND_ALWAYS, hold: 1'b0, target: ST_WAIT_IN};
        unique case (s)
            ST_WAIT_IN:
                c = '{op: OP_LATCH, cond: CND_IN_FIRE, hold: 1'b1, target: ST_MUL_V};
            ST_MUL_V:
                c = '{op: OP_MUL_V, cond: CND_NEVER, hold: 1'b0, target: ST_WAIT_IN};
            ST_ADD_V:
                c = '{op: OP_ADD_V, cond: CND_NEVER, hold: 1'b0, target: ST_WAIT_IN};
            ST_MUL_P:
                c = '{op: OP_MUL_P, cond: CND_NEVER, hold: 1'b0, target: ST_WAIT_IN};
            ST_ADD_P:
                c = '{op: OP_ADD_P, cond: CND_NEVER, hold: 1'b0, target: ST_WAIT_IN};
            ST_CHECK:
                c = '{op: OP_CHECK, cond: CND_DONE, hold: 1'b0, target: ST_FINISH};
            ST_DIV_INIT:
                c = '{op: OP_DIV_INIT, cond: CND_TZERO, hold: 1'b0, target: ST_DRIVE_SIGN};
            ST_DIV_STEP:
                c = '{op: OP_DIV_STEP, cond: CND_CNT_NZ, hold: 1'b0, target: ST_DIV_STEP};
            ST_DRIVE_DIV:
                c = '{op: OP_DRIVE_DIV, cond: CND_ALWAYS, hold: 1'b0, target: ST_EMIT};
            ST_DRIVE_SIGN:
                c = '{op: OP_DRIVE_SIGN, cond: CND_ALWAYS, hold: 1'b0, target: ST_EMIT};
            ST_FINISH:
                c = '{op: OP_FINISH, cond: CND_NEVER, hold: 1'b0, target: ST_WAIT_IN};
            ST_EMIT:
                c = '{op: OP_EMIT, cond: CND_OUT_FREE, hold: 1'b1, target: ST_WAIT_IN};
            default:
                c = '{op: OP_EMIT, cond: CND_ALWAYS, hold: 1'b0, target: ST_WAIT_IN};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/drm_if.sv @@
// tick and result channel interfaces
`default_nettype none

// one accelerometer sample plus pid output per word
interface drm_tick_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_sample;
    logic signed [31:0] pid_output;

    modport source (output valid, accel_sample, pid_output, input ready);
    modport sink   (input valid, accel_sample, pid_output, output ready);
endinterface

// position, drive and arrival flag per word
interface drm_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [15:0] drive_command;
    logic               finished;

    modport source (output valid, position, drive_command, finished, input ready);
    modport sink   (input valid, position, drive_command, finished, output ready);
endinterface

`default_nettype wire

@@ hdl/drm_seq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
`default_nettype none

module drm_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire drm_pkg::flags_t flags,
    output drm_pkg::ctrl_t       ctrl,
    output drm_pkg::step_t       step
);
    import drm_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take;

    // control word for the current step
    always_comb ctrl = seq_rom(step_reg);

    // jump condition select
    always_comb
    begin
        unique case (ctrl.cond)
            CND_NEVER:    take = 1'b0;
            CND_ALWAYS:   take = 1'b1;
            CND_IN_FIRE:  take = flags.in_fire;
            CND_OUT_FREE: take = flags.out_free;
            CND_DONE:     take = flags.done;
            CND_TZERO:    take = flags.tzero;
            CND_CNT_NZ:   take = flags.cnt_nz;
            default:      take = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        priority if (take)
            step_next = ctrl.target;
        else if (ctrl.hold)
            step_next = step_reg;
        else
            step_next = step_reg + step_t'(1);
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_WAIT_IN;
        else
            step_reg <= step_next;
    end

    assign step = step_reg;

endmodule

`default_nettype wire

@@ hdl/accel_dead_reckon_move.sv @@
// dead-reckoning move block: double integration of acceleration and drive scaling
//
//  channel  dir  handshake      payload
//  tick     in   valid/ready    accel_sample, pid_output
//  result   out  valid/ready    position, drive_command, finished
//  cfg      in   cfg_we         cfg_index, cfg_data (write only)
//
// A tick runs these steps when the drive needs the divide: take the word, four
// integrate steps, arrival check, divider setup, 15 restoring divider steps (one
// quotient bit each), drive forming and emit. A finished move skips the divider
// and clears the integrators; a zero target skips the divider steps and drives by sign.
// Reset clears velocity, position and the registers to their defaults at once.
// A stalled result holds the emit step; the next word is not taken while it waits.
`default_nettype none

module accel_dead_reckon_move #(
    parameter int POS_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [drm_pkg::CFG_DATA_W-1:0]   cfg_data,
    drm_tick_if.sink                              tick,
    drm_result_if.source                          result
);
    import drm_pkg::*;

    // internal widths
    localparam int PROD_W = 49;
    localparam int PSW    = ((POS_WIDTH > 34) ? POS_WIDTH : 34) + 1;
    localparam int XW     = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam int EW     = ((POS_WIDTH > 24) ? POS_WIDTH : 24) + 1;
    localparam int REM_W  = 32 + 14;
    localparam int DSH_W  = 24 + DIV_BITS;

    localparam logic signed [PSW-1:0] PMAX = {{(PSW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [PSW-1:0] PMIN = ~PMAX;
    localparam logic signed [XW-1:0]  OMAX = {{(XW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [XW-1:0]  OMIN = ~OMAX;

    // sequencer
    ctrl_t  ctrl;
    step_t  step;
    flags_t flags;

    // configuration registers
    logic signed [23:0] target_reg;
    logic signed [15:0] offset_reg;
    logic [15:0]        gain_reg;
    logic [15:0]        period_reg;
    logic [15:0]        tol_reg;

    // integrator state
    logic signed [31:0]          vel_reg;
    logic signed [31:0]          vel_next;
    logic signed [POS_WIDTH-1:0] pos_reg;
    logic signed [POS_WIDTH-1:0] pos_next;

    // per-tick working registers
    logic signed [15:0]       accel_reg;
    logic signed [31:0]       pid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [31:0]       res_pos_reg;
    logic                     done_reg;
    logic signed [15:0]       drive_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [DSH_W-1:0]         dsh_reg;
    logic [DIV_BITS-1:0]      quo_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         cnt_reg;

    // output register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [31:0] out_pos_reg;
    logic signed [15:0] out_drive_reg;
    logic               out_fin_reg;

    // datapath nets
    logic               in_fire;
    logic               out_free;
    logic signed [16:0] diff;
    logic signed [32:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [49:0] mul_full;
    logic signed [33:0] vr_sum;
    logic signed [33:0] v_sum;
    logic signed [31:0] v_sat;
    logic signed [49:0] pr_sum;
    logic signed [PSW-1:0] p_sum;
    logic signed [POS_WIDTH-1:0] p_sat;
    logic signed [XW-1:0] pos_x;
    logic signed [31:0] rep_pos;
    logic signed [EW-1:0] err;
    logic [EW-1:0]      err_mag;
    logic               done_now;
    logic [23:0]        tgt_mag;
    logic [31:0]        pid_mag;
    logic               rem_ge;
    logic [15:0]        q_mag;
    logic signed [15:0] drive_div;
    logic signed [15:0] drive_sgn;

    drm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .step  (step)
    );

    // handshakes
    assign tick.ready = (step == ST_WAIT_IN);
    assign in_fire    = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || result.ready;

    // shared multiplier: offset-corrected sample times gain, or velocity times period
    assign diff     = 17'(accel_reg) - 17'(offset_reg);
    assign mul_a    = (ctrl.op == OP_MUL_P) ? 33'(vel_reg) : 33'(diff);
    assign mul_b    = (ctrl.op == OP_MUL_P) ? period_reg : gain_reg;
    assign mul_full = mul_a * $signed({1'b0, mul_b});

    // velocity update, round half up by 2^12 and saturate to 32 bits
    assign vr_sum = 34'($signed(prod_reg[32:0])) + 34'sd2048;
    assign v_sum  = 34'(vel_reg) + 34'($signed(vr_sum[33:12]));
    always_comb
    begin
        priority if (v_sum > 34'sd2147483647)
            v_sat = 32'sh7fffffff;
        else if (v_sum < -34'sd2147483648)
            v_sat = 32'sh80000000;
        else
            v_sat = v_sum[31:0];
    end

    // position update, round half up by 2^16 and saturate to the accumulator width
    assign pr_sum = 50'(prod_reg) + 50'sd32768;
    assign p_sum  = PSW'(pos_reg) + PSW'($signed(pr_sum[49:16]));
    always_comb
    begin
        priority if (p_sum > PMAX)
            p_sat = PMAX[POS_WIDTH-1:0];
        else if (p_sum < PMIN)
            p_sat = PMIN[POS_WIDTH-1:0];
        else
            p_sat = p_sum[POS_WIDTH-1:0];
    end

    // reported position clipped to 32 bits
    assign pos_x = XW'(pos_reg);
    always_comb
    begin
        priority if (pos_x > OMAX)
            rep_pos = 32'sh7fffffff;
        else if (pos_x < OMIN)
            rep_pos = 32'sh80000000;
        else
            rep_pos = pos_x[31:0];
    end

    // arrival test
    assign err      = EW'(target_reg) - EW'(pos_reg);
    assign err_mag  = err[EW-1] ? $unsigned(-err) : $unsigned(err);
    assign done_now = err_mag < EW'(tol_reg);

    // divider operands and trial compare
    assign tgt_mag = target_reg[23] ? $unsigned(-target_reg) : $unsigned(target_reg);
    assign pid_mag = pid_reg[31] ? $unsigned(-pid_reg) : $unsigned(pid_reg);
    assign rem_ge  = REM_W'(dsh_reg) <= rem_reg;

    // drive forming
    assign q_mag     = (ovf_reg || (quo_reg > QUO_FULL)) ? 16'(QUO_FULL) : 16'(quo_reg);
    assign drive_div = pid_reg[31] ? (16'd0 - q_mag) : q_mag;
    always_comb
    begin
        priority if (pid_reg[31])
            drive_sgn = DRIVE_NEG;
        else if (pid_reg != '0)
            drive_sgn = DRIVE_POS;
        else
            drive_sgn = '0;
    end

    // sequencer status
    always_comb
    begin
        flags.in_fire  = in_fire;
        flags.out_free = out_free;
        flags.done     = done_now;
        flags.tzero    = (target_reg == '0);
        flags.cnt_nz   = (cnt_reg != '0);
    end

    // integrator next values
    always_comb
    begin
        vel_next = vel_reg;
        pos_next = pos_reg;
        unique case (ctrl.op)
            OP_ADD_V:  vel_next = v_sat;
            OP_ADD_P:  pos_next = p_sat;
            OP_FINISH:
            begin
                vel_next = '0;
                pos_next = '0;
            end
            default: ;
        endcase
    end

    // output valid next value
    always_comb
    begin
        priority if ((ctrl.op == OP_EMIT) && out_free)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // configuration, integrator state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            offset_reg    <= '0;
            gain_reg      <= GAIN_RST;
            period_reg    <= PERIOD_RST;
            tol_reg       <= TOL_RST;
            vel_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data[23:0];
                    REG_OFFSET: offset_reg <= cfg_data[15:0];
                    REG_GAIN:   gain_reg   <= cfg_data[15:0];
                    REG_PERIOD: period_reg <= cfg_data[15:0];
                    REG_TOL:    tol_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
            vel_reg       <= vel_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers driven by the current micro-op
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LATCH:
            begin
                if (in_fire)
                begin
                    accel_reg <= tick.accel_sample;
                    pid_reg   <= tick.pid_output;
                end
            end
            OP_MUL_V, OP_MUL_P:
                prod_reg <= mul_full[PROD_W-1:0];
            OP_CHECK:
            begin
                res_pos_reg <= rep_pos;
                done_reg    <= done_now;
                rem_reg     <= {pid_mag, 14'd0};
                dsh_reg     <= {tgt_mag, {DIV_BITS{1'b0}}};
            end
            OP_DIV_INIT:
            begin
                ovf_reg <= rem_ge;
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= CNT_W'(DIV_BITS - 1);
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                if (rem_ge)
                begin
                    rem_reg <= rem_reg - REM_W'(dsh_reg);
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            OP_DRIVE_DIV:  drive_reg <= drive_div;
            OP_DRIVE_SIGN: drive_reg <= drive_sgn;
            OP_FINISH:     drive_reg <= '0;
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if ((ctrl.op == OP_EMIT) && out_free)
        begin
            out_pos_reg   <= res_pos_reg;
            out_drive_reg <= drive_reg;
            out_fin_reg   <= done_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.position      = out_pos_reg;
    assign result.drive_command = out_drive_reg;
    assign result.finished      = out_fin_reg;

    // a new result word only comes out of the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step) == ST_EMIT)
        else $error("result valid rose outside the emit step");

    // a finished word never drives the motor
    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_fin_reg |-> out_drive_reg == '0)
        else $error("finished word with nonzero drive");

    // arrival clears both integrators
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(step) == ST_FINISH |-> vel_reg == '0 && pos_reg == '0)
        else $error("integrators not cleared after arrival");

    // divider steps only follow its setup or another step
    a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
        step == ST_DIV_STEP |-> $past(step) == ST_DIV_INIT || $past(step) == ST_DIV_STEP)
        else $error("divider step entered out of order");

endmodule

`default_nettype wire
